[hw/rtl/qte_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package qte_pkg;

  localparam int COMP_W     = 16;
  localparam int PROD_W     = 32;
  localparam int VEC_W      = 36;
  localparam int ANG_W      = 27;
  localparam int RND_W      = ANG_W + 1;
  localparam int PITCH_W    = 15;
  localparam int EUL_W      = 16;
  localparam int WRAP_W     = 18;
  localparam int THR_W      = 29;
  localparam int SINE_W     = 30;
  localparam int SQ_PROD_W  = 2 * SINE_W;
  localparam int SQ_W       = 58;
  localparam int SQRT_STEPS = 29;
  localparam int ATAN_LEN   = 24;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;
  localparam int A_SHIFT    = 14;

  localparam logic [THR_W-1:0]        THR_RESET   = 29'd134217594;
  localparam logic signed [VEC_W-1:0] ONE_Q28     = 36'sd268435456;
  localparam logic [SQ_W-1:0]         ONE_Q56     = SQ_W'(1) << 56;
  localparam logic signed [ANG_W-1:0] DEG180_FINE = 27'sd11796480;
  localparam logic signed [RND_W-1:0] RND_HALF    = 28'sd256;
  localparam int                      RND_SHIFT   = 9;

  localparam int HALF_TURN    = 23040;
  localparam int QUARTER_TURN = 11520;
  localparam int FULL_TURN    = 46080;

  localparam logic [0:0] REG_THRESHOLD = 1'b0;

  typedef enum logic [1:0] {
    POLE_NONE  = 2'd0,
    POLE_SOUTH = 2'd1,
    POLE_NORTH = 2'd2
  } pole_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] quat_x;
    logic signed [COMP_W-1:0] quat_y;
    logic signed [COMP_W-1:0] quat_z;
    logic signed [COMP_W-1:0] quat_w;
  } quat_t;

  typedef struct packed {
    logic signed [PITCH_W-1:0] pitch_angle;
    logic signed [EUL_W-1:0]   yaw_angle;
    logic signed [EUL_W-1:0]   roll_angle;
    pole_t                     pole_case;
  } euler_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] yaw_y;
    logic signed [VEC_W-1:0] yaw_x;
    logic signed [VEC_W-1:0] roll_y;
    logic signed [VEC_W-1:0] roll_x;
    logic signed [VEC_W-1:0] sine;
    pole_t                   pole;
  } side_t;

  // atan(2^-i) in 1/65536 degree
  function automatic logic signed [ANG_W-1:0] atan_fine(input int i);
    logic signed [ANG_W-1:0] r;
    unique case (i)
      0:  r = 27'sd2949120;
      1:  r = 27'sd1740967;
      2:  r = 27'sd919879;
      3:  r = 27'sd466945;
      4:  r = 27'sd234379;
      5:  r = 27'sd117304;
      6:  r = 27'sd58666;
      7:  r = 27'sd29335;
      8:  r = 27'sd14668;
      9:  r = 27'sd7334;
      10: r = 27'sd3667;
      11: r = 27'sd1833;
      12: r = 27'sd917;
      13: r = 27'sd458;
      14: r = 27'sd229;
      15: r = 27'sd115;
      16: r = 27'sd57;
      17: r = 27'sd29;
      18: r = 27'sd14;
      19: r = 27'sd7;
      20: r = 27'sd4;
      21: r = 27'sd2;
      22: r = 27'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/qte_sqrt_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module qte_sqrt_cell #(
  parameter int STEP = 0
) (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic [qte_pkg::SQ_W-1:0]  rem_in,
  input  wire logic [qte_pkg::SQ_W-1:0]  root_in,
  output logic      [qte_pkg::SQ_W-1:0]  rem_out,
  output logic      [qte_pkg::SQ_W-1:0]  root_out
);

  localparam logic [qte_pkg::SQ_W-1:0] BIT =
    qte_pkg::SQ_W'(1) << (2 * (qte_pkg::SQRT_STEPS - 1 - STEP));

  logic [qte_pkg::SQ_W-1:0] trial;

  assign trial = root_in + BIT;

  always_ff @(posedge clk) begin
    if (en) begin
      if (rem_in >= trial) begin
        rem_out  <= rem_in - trial;
        root_out <= (root_in >> 1) + BIT;
      end else begin
        rem_out  <= rem_in;
        root_out <= root_in >> 1;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/qte_cordic_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module qte_cordic_cell #(
  parameter int STEP = 0
) (
  input  wire logic                               clk,
  input  wire logic                               en,
  input  wire logic signed [qte_pkg::VEC_W-1:0]   x_in,
  input  wire logic signed [qte_pkg::VEC_W-1:0]   y_in,
  input  wire logic signed [qte_pkg::ANG_W-1:0]   z_in,
  output logic      signed [qte_pkg::VEC_W-1:0]   x_out,
  output logic      signed [qte_pkg::VEC_W-1:0]   y_out,
  output logic      signed [qte_pkg::ANG_W-1:0]   z_out
);

  localparam logic signed [qte_pkg::ANG_W-1:0] ATAN = qte_pkg::atan_fine(STEP);

  logic signed [qte_pkg::VEC_W-1:0] xs;
  logic signed [qte_pkg::VEC_W-1:0] ys;

  assign xs = x_in >>> STEP;
  assign ys = y_in >>> STEP;

  always_ff @(posedge clk) begin
    if (en) begin
      if (!y_in[qte_pkg::VEC_W-1]) begin
        x_out <= x_in + ys;
        y_out <= y_in - xs;
        z_out <= z_in + ATAN;
      end else begin
        x_out <= x_in - ys;
        y_out <= y_in + xs;
        z_out <= z_in - ATAN;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/qte_cordic.sv]
`timescale 1ns / 1ps
`default_nettype none

module qte_cordic #(
  parameter int STAGES = 16
) (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic signed [qte_pkg::VEC_W-1:0]  vec_y,
  input  wire logic signed [qte_pkg::VEC_W-1:0]  vec_x,
  output logic      signed [qte_pkg::EUL_W-1:0]  angle
);

  logic signed [qte_pkg::VEC_W-1:0] x_c [STAGES+1];
  logic signed [qte_pkg::VEC_W-1:0] y_c [STAGES+1];
  logic signed [qte_pkg::ANG_W-1:0] z_c [STAGES+1];
  logic        [STAGES:0]           zero_d;
  logic signed [qte_pkg::RND_W-1:0] z_rnd;

  // quadrant fold
  always_ff @(posedge clk) begin
    if (en) begin
      zero_d[0] <= (vec_x == '0) && (vec_y == '0);
      if (vec_x[qte_pkg::VEC_W-1]) begin
        x_c[0] <= -vec_x;
        y_c[0] <= -vec_y;
        z_c[0] <= vec_y[qte_pkg::VEC_W-1] ? -qte_pkg::DEG180_FINE : qte_pkg::DEG180_FINE;
      end else begin
        x_c[0] <= vec_x;
        y_c[0] <= vec_y;
        z_c[0] <= '0;
      end
      zero_d[STAGES:1] <= zero_d[STAGES-1:0];
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    qte_cordic_cell #(.STEP(i)) u_cell (
      .clk   (clk),
      .en    (en),
      .x_in  (x_c[i]),
      .y_in  (y_c[i]),
      .z_in  (z_c[i]),
      .x_out (x_c[i+1]),
      .y_out (y_c[i+1]),
      .z_out (z_c[i+1])
    );
  end

  assign z_rnd = (qte_pkg::RND_W'(z_c[STAGES]) + qte_pkg::RND_HALF) >>> qte_pkg::RND_SHIFT;

  always_ff @(posedge clk) begin
    if (en) begin
      if (zero_d[STAGES]) begin
        angle <= '0;
      end else if (z_rnd > qte_pkg::HALF_TURN) begin
        angle <= qte_pkg::EUL_W'(qte_pkg::HALF_TURN);
      end else if (z_rnd < -qte_pkg::HALF_TURN) begin
        angle <= qte_pkg::EUL_W'(-qte_pkg::HALF_TURN);
      end else begin
        angle <= z_rnd[qte_pkg::EUL_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/quaternion_to_euler_angles.sv]
`timescale 1ns / 1ps
`default_nettype none

// Quaternion (Q2.14) to pitch/yaw/roll in 1/128 degree, with a pole flag.
// Input channel quat_valid/quat_ready/quat, result channel
// euler_valid/euler_ready/euler; an item moves when valid and ready are high.
// One result per item, in order. Fully pipelined: one item per cycle while no result waits on euler_ready.
// The pipe runs from acceptance to euler_valid through five
// product/sum stages, a 29-cell square-root chain, then three parallel
// CORDIC chains of CORDIC_STAGES cells plus fold and rounding registers, then the output register.
// The whole pipe advances together; while a result waits on euler_ready
// the pipe holds and quat_ready is low, otherwise quat_ready is high.
// Reset empties the pipe and loads the pole threshold with its default.
// The threshold sits at APB byte address 0; write it only while idle.
module quaternion_to_euler_angles #(
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          quat_valid,
  output logic                               quat_ready,
  input  wire qte_pkg::quat_t                quat,
  output logic                               euler_valid,
  input  wire logic                          euler_ready,
  output qte_pkg::euler_t                    euler,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [qte_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [qte_pkg::DATA_W-1:0]    pwdata,
  output logic      [qte_pkg::DATA_W-1:0]    prdata,
  output logic                               pready
);

  localparam int SIDE_DLY = qte_pkg::SQRT_STEPS + 2;
  localparam int POLE_DLY = CORDIC_STAGES + 2;
  localparam int LAT      = CORDIC_STAGES + 37;

  logic                      advance;
  logic [LAT-1:0]            vld;
  logic [qte_pkg::THR_W-1:0] thr;

  // config
  assign pready = 1'b1;
  assign prdata = (paddr[2] == qte_pkg::REG_THRESHOLD) ? qte_pkg::DATA_W'(thr) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= qte_pkg::THR_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == qte_pkg::REG_THRESHOLD) begin
      thr <= pwdata[qte_pkg::THR_W-1:0];
    end
  end

  assign advance     = !euler_valid || euler_ready;
  assign quat_ready  = advance;
  assign euler_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[LAT-2:0], quat_valid};
    end
  end

  // s0: input register, s1: products
  qte_pkg::quat_t q0;
  logic signed [qte_pkg::PROD_W-1:0] p_xx, p_yy, p_zz, p_xy, p_zx, p_yz, p_wx, p_wy, p_wz;
  logic signed [qte_pkg::COMP_W-1:0] z1, w1;

  always_ff @(posedge clk) begin
    if (advance) begin
      q0   <= quat;
      p_xx <= q0.quat_x * q0.quat_x;
      p_yy <= q0.quat_y * q0.quat_y;
      p_zz <= q0.quat_z * q0.quat_z;
      p_xy <= q0.quat_x * q0.quat_y;
      p_zx <= q0.quat_z * q0.quat_x;
      p_yz <= q0.quat_y * q0.quat_z;
      p_wx <= q0.quat_w * q0.quat_x;
      p_wy <= q0.quat_w * q0.quat_y;
      p_wz <= q0.quat_w * q0.quat_z;
      z1   <= q0.quat_z;
      w1   <= q0.quat_w;
    end
  end

  // s2: sums, pole test
  logic signed [qte_pkg::VEC_W-1:0] test, sine2, thr_s, yaw_y, yaw_x, roll_y, roll_x;
  logic signed [qte_pkg::VEC_W-1:0] a_y, a_x;
  qte_pkg::side_t side_next, side2;

  assign thr_s  = qte_pkg::VEC_W'(thr);
  assign test   = qte_pkg::VEC_W'(p_yz) - qte_pkg::VEC_W'(p_wx);
  assign sine2  = test <<< 1;
  assign yaw_y  = (qte_pkg::VEC_W'(p_wy) + qte_pkg::VEC_W'(p_zx)) <<< 1;
  assign yaw_x  = qte_pkg::ONE_Q28 - ((qte_pkg::VEC_W'(p_xx) + qte_pkg::VEC_W'(p_yy)) <<< 1);
  assign roll_y = -((qte_pkg::VEC_W'(p_wz) + qte_pkg::VEC_W'(p_xy)) <<< 1);
  assign roll_x = qte_pkg::ONE_Q28 - ((qte_pkg::VEC_W'(p_zz) + qte_pkg::VEC_W'(p_xx)) <<< 1);
  assign a_y    = qte_pkg::VEC_W'(z1) <<< qte_pkg::A_SHIFT;
  assign a_x    = qte_pkg::VEC_W'(w1) <<< qte_pkg::A_SHIFT;

  always_comb begin
    side_next.yaw_y = yaw_y;
    side_next.yaw_x = yaw_x;
    priority if (test < -thr_s) begin
      side_next.pole = qte_pkg::POLE_SOUTH;
    end else if (test > thr_s) begin
      side_next.pole = qte_pkg::POLE_NORTH;
    end else begin
      side_next.pole = qte_pkg::POLE_NONE;
    end
    // pole items reuse the roll unit for atan2(z, w)
    if (side_next.pole == qte_pkg::POLE_NONE) begin
      side_next.roll_y = roll_y;
      side_next.roll_x = roll_x;
    end else begin
      side_next.roll_y = a_y;
      side_next.roll_x = a_x;
    end
    priority if (sine2 > qte_pkg::ONE_Q28) begin
      side_next.sine = qte_pkg::ONE_Q28;
    end else if (sine2 < -qte_pkg::ONE_Q28) begin
      side_next.sine = -qte_pkg::ONE_Q28;
    end else begin
      side_next.sine = sine2;
    end
  end

  // s3: square, s4: 1 - s^2
  logic signed [qte_pkg::SINE_W-1:0]    s_nar;
  logic signed [qte_pkg::SQ_PROD_W-1:0] sq;
  logic        [qte_pkg::SQ_W-1:0]      rem4;

  assign s_nar = side2.sine[qte_pkg::SINE_W-1:0];

  always_ff @(posedge clk) begin
    if (advance) begin
      side2 <= side_next;
      sq    <= s_nar * s_nar;
      rem4  <= qte_pkg::ONE_Q56 - sq[qte_pkg::SQ_W-1:0];
    end
  end

  // square-root chain
  logic [qte_pkg::SQ_W-1:0] rem_c  [qte_pkg::SQRT_STEPS+1];
  logic [qte_pkg::SQ_W-1:0] root_c [qte_pkg::SQRT_STEPS+1];

  assign rem_c[0]  = rem4;
  assign root_c[0] = '0;

  for (genvar j = 0; j < qte_pkg::SQRT_STEPS; j++) begin : g_sqrt
    qte_sqrt_cell #(.STEP(j)) u_sqrt (
      .clk      (clk),
      .en       (advance),
      .rem_in   (rem_c[j]),
      .root_in  (root_c[j]),
      .rem_out  (rem_c[j+1]),
      .root_out (root_c[j+1])
    );
  end

  qte_pkg::side_t side_d [SIDE_DLY];

  always_ff @(posedge clk) begin
    if (advance) begin
      side_d[0] <= side2;
      for (int k = 1; k < SIDE_DLY; k++) begin
        side_d[k] <= side_d[k-1];
      end
    end
  end

  qte_pkg::side_t                    side_c;
  logic signed [qte_pkg::VEC_W-1:0]  cos_c;
  logic signed [qte_pkg::EUL_W-1:0]  pitch_a, yaw_a, roll_a;

  assign side_c = side_d[SIDE_DLY-1];
  assign cos_c  = qte_pkg::VEC_W'(root_c[qte_pkg::SQRT_STEPS]);

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
    .clk (clk), .en (advance), .vec_y (side_c.sine), .vec_x (cos_c), .angle (pitch_a)
  );

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
    .clk (clk), .en (advance), .vec_y (side_c.yaw_y), .vec_x (side_c.yaw_x), .angle (yaw_a)
  );

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
    .clk (clk), .en (advance), .vec_y (side_c.roll_y), .vec_x (side_c.roll_x), .angle (roll_a)
  );

  qte_pkg::pole_t pole_d [POLE_DLY];

  always_ff @(posedge clk) begin
    if (advance) begin
      pole_d[0] <= side_c.pole;
      for (int k = 1; k < POLE_DLY; k++) begin
        pole_d[k] <= pole_d[k-1];
      end
    end
  end

  // output stage
  qte_pkg::pole_t                     pole_o;
  logic signed [qte_pkg::WRAP_W-1:0]  roll_raw, roll_wrap;
  qte_pkg::euler_t                    euler_next;

  assign pole_o = pole_d[POLE_DLY-1];

  always_comb begin
    if (pole_o == qte_pkg::POLE_SOUTH) begin
      roll_raw = -qte_pkg::WRAP_W'(yaw_a) - (qte_pkg::WRAP_W'(roll_a) <<< 1);
    end else begin
      roll_raw = qte_pkg::WRAP_W'(yaw_a) - (qte_pkg::WRAP_W'(roll_a) <<< 1);
    end
    priority if (roll_raw > qte_pkg::HALF_TURN) begin
      roll_wrap = roll_raw - qte_pkg::WRAP_W'(qte_pkg::FULL_TURN);
    end else if (roll_raw > -qte_pkg::HALF_TURN) begin
      roll_wrap = roll_raw;
    end else if (roll_raw > -qte_pkg::HALF_TURN - qte_pkg::FULL_TURN) begin
      roll_wrap = roll_raw + qte_pkg::WRAP_W'(qte_pkg::FULL_TURN);
    end else begin
      roll_wrap = roll_raw + qte_pkg::WRAP_W'(2 * qte_pkg::FULL_TURN);
    end

    euler_next.yaw_angle = yaw_a;
    euler_next.pole_case = pole_o;
    unique case (pole_o)
      qte_pkg::POLE_SOUTH: begin
        euler_next.pitch_angle = qte_pkg::PITCH_W'(-qte_pkg::QUARTER_TURN);
        euler_next.roll_angle  = roll_wrap[qte_pkg::EUL_W-1:0];
      end
      qte_pkg::POLE_NORTH: begin
        euler_next.pitch_angle = qte_pkg::PITCH_W'(qte_pkg::QUARTER_TURN);
        euler_next.roll_angle  = roll_wrap[qte_pkg::EUL_W-1:0];
      end
      default: begin
        if (pitch_a > qte_pkg::QUARTER_TURN) begin
          euler_next.pitch_angle = qte_pkg::PITCH_W'(qte_pkg::QUARTER_TURN);
        end else if (pitch_a < -qte_pkg::QUARTER_TURN) begin
          euler_next.pitch_angle = qte_pkg::PITCH_W'(-qte_pkg::QUARTER_TURN);
        end else begin
          euler_next.pitch_angle = pitch_a[qte_pkg::PITCH_W-1:0];
        end
        euler_next.roll_angle = roll_a;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      euler <= euler_next;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !euler_valid)
    else $error("result valid right after reset");

  a_south_pitch: assert property (@(posedge clk) disable iff (rst)
    euler_valid && euler.pole_case == qte_pkg::POLE_SOUTH
      |-> euler.pitch_angle == -qte_pkg::QUARTER_TURN)
    else $error("south pole item without -90 pitch");

  a_north_pitch: assert property (@(posedge clk) disable iff (rst)
    euler_valid && euler.pole_case == qte_pkg::POLE_NORTH
      |-> euler.pitch_angle == qte_pkg::QUARTER_TURN)
    else $error("north pole item without +90 pitch");

  a_roll_range: assert property (@(posedge clk) disable iff (rst)
    euler_valid |-> euler.roll_angle <= qte_pkg::HALF_TURN
                    && euler.roll_angle >= -qte_pkg::HALF_TURN)
    else $error("roll out of range");

endmodule

`default_nettype wire
